@@ sv/fra_pkg.sv @@
// shared types and constants for the free range allocator
`default_nettype none
package fra_pkg;
  localparam int unsigned MaxRangesDefault = 256;
  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned FieldBits = 32;
  localparam int unsigned CountBits = 9;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [FieldBits-1:0] start_value;
    logic [FieldBits-1:0] end_value;
    logic [FieldBits-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [FieldBits-1:0] range_start;
    logic [FieldBits-1:0] range_end;
    logic [CountBits-1:0] range_count;
  } out_item_t;
endpackage
`default_nettype wire

@@ sv/free_range_allocator.sv @@
// free range allocator: sorted table of free ranges in one memory
//
// Input beats on in_valid/in_ready carry a command (put, get, find, clear)
// with its operands; each accepted beat yields exactly one result beat on
// out_valid/out_ready, in order. One command is worked at a time.
// The ranges sit in a single-port synchronous memory of MAX_RANGES entries,
// each entry holding a start and an end; read data arrives in the cycle
// after its address. The steps per command:
//   find       : a scan of the entries, from the lowest up
//   get        : entry 0 is trimmed, or taken whole when it is no larger
//                than the amount, and the tail then compacts down
//   put        : scan to the insert point, then a shift of the tail by one
//                entry (insert) or a merge pass that compacts the tail
//   clear      : the count is set to zero
// Each step uses the one memory port, one access per cycle. The result
// sits in an output register; the next command is taken only once that
// register is free, so a stalled receiver holds the block. Reset (rst_n
// low, synchronous) empties the table at once; the memory contents need
// no clearing since only entries below the count are ever read.
`default_nettype none
module free_range_allocator
  import fra_pkg::*;
#(
  parameter int unsigned MAX_RANGES = MaxRangesDefault,
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);
  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned EW = 2 * VW;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
    S_MERGE_RD, S_MERGE_W, S_COMPACT_RD, S_COMPACT_WR, S_FIN_WR, S_DONE
  } state_t;

  logic [EW-1:0] mem [MAX_RANGES];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_q <= mem[mem_addr];
  end

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // scan / shift pointer
  logic [CW-1:0] src_r, src_nxt;   // compaction read pointer
  logic [1:0]    cmd_r, cmd_nxt;
  logic [VW-1:0] sv_r, sv_nxt, ev_r, ev_nxt, amt_r, amt_nxt;
  logic [VW-1:0] ps_r, ps_nxt, pe_r, pe_nxt;   // previous entry seen
  logic          hp_r, hp_nxt;                 // previous entry exists
  logic [VW-1:0] ks_r, ks_nxt, ke_r, ke_nxt;   // merged entry
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  wire [VW-1:0] rd_s = rd_q[EW-1:VW];
  wire [VW-1:0] rd_e = rd_q[VW-1:0];
  wire [VW-1:0] ones_v = '1;

  function automatic logic [FieldBits-1:0] to_out(input logic [VW-1:0] v);
    logic [FieldBits+VW-1:0] w;
    w = {{FieldBits{1'b0}}, v};
    return w[FieldBits-1:0];
  endfunction

  function automatic logic [VW-1:0] to_val(input logic [FieldBits-1:0] v);
    logic [FieldBits+VW-1:0] w;
    w = {{VW{1'b0}}, v};
    return w[VW-1:0];
  endfunction

  function automatic logic [CountBits-1:0] to_cnt(input logic [CW-1:0] v);
    logic [CountBits+CW-1:0] w;
    w = {{CountBits{1'b0}}, v};
    return w[CountBits-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r; src_nxt = src_r;
    cmd_nxt = cmd_r; sv_nxt = sv_r; ev_nxt = ev_r; amt_nxt = amt_r;
    ps_nxt = ps_r; pe_nxt = pe_r; hp_nxt = hp_r; ks_nxt = ks_r; ke_nxt = ke_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    mem_we = 1'b0; mem_addr = idx_r[AW-1:0]; mem_wd = {ks_r, ke_r};
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = in_data.cmd;
          sv_nxt  = to_val(in_data.start_value);
          ev_nxt  = to_val(in_data.end_value);
          amt_nxt = to_val(in_data.amount);
          idx_nxt = '0;
          hp_nxt  = 1'b0;
          mem_addr = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // finish the commands that need no scan; otherwise read the next entry or go to decide
        out_nxt.range_start = '0;
        out_nxt.range_end   = '0;
        out_nxt.status      = ST_OK;
        priority if (cmd_r == CMD_CLEAR) begin
          count_nxt = '0; state_nxt = S_DONE;
        end else if (cmd_r == CMD_PUT && (ev_r == '0 || ev_r < sv_r)) begin
          out_nxt.status = ST_BAD; state_nxt = S_DONE;
        end else if (cmd_r == CMD_PUT && ev_r == sv_r) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_GET) begin
          if (count_r == '0 || amt_r == '0) begin
            out_nxt.status = ST_NONE;
            out_nxt.range_start = to_out(ones_v);
            out_nxt.range_end = to_out(ones_v);
            state_nxt = S_DONE;
          end else begin
            mem_addr = '0; state_nxt = S_SCAN_W;
          end
        end else begin
          if (idx_r < count_r) begin
            mem_addr = idx_r[AW-1:0]; state_nxt = S_SCAN_W;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_SCAN_W: begin
        if (cmd_r == CMD_GET) begin
          out_nxt.range_start = to_out(rd_s);
          if (rd_e - rd_s > amt_r) begin
            out_nxt.range_end = to_out(rd_s + amt_r);
            ks_nxt = rd_s + amt_r; ke_nxt = rd_e;
            idx_nxt = '0; state_nxt = S_FIN_WR;
          end else begin
            out_nxt.range_end = to_out(rd_e);
            // remove entry 0: compact everything down by one
            idx_nxt = '0; src_nxt = CW'(1); state_nxt = S_COMPACT_RD;
          end
        end else if (rd_s < sv_r) begin
          ps_nxt = rd_s; pe_nxt = rd_e; hp_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_SCAN;
        end else begin
          ks_nxt = rd_s; ke_nxt = rd_e;  // entry at p
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // idx_r = p; ks/ke hold entry p when p < count
        if (cmd_r == CMD_FIND) begin
          if (idx_r < count_r && ks_r == sv_r) begin
            out_nxt.range_start = to_out(ks_r); out_nxt.range_end = to_out(ke_r);
          end else if (hp_r && pe_r > sv_r) begin
            out_nxt.range_start = to_out(ps_r); out_nxt.range_end = to_out(pe_r);
          end else begin
            out_nxt.status = ST_NONE;
            out_nxt.range_start = to_out(ones_v);
            out_nxt.range_end = to_out(ones_v);
          end
          state_nxt = S_DONE;
        end else if (hp_r && pe_r >= sv_r) begin
          idx_nxt = idx_r - CW'(1);
          ks_nxt = ps_r; ke_nxt = (ev_r > pe_r) ? ev_r : pe_r;
          src_nxt = idx_r; state_nxt = S_MERGE_RD;
        end else if (idx_r < count_r && ev_r >= ks_r) begin
          ks_nxt = sv_r; ke_nxt = (ev_r > ke_r) ? ev_r : ke_r;
          src_nxt = idx_r + CW'(1); state_nxt = S_MERGE_RD;
        end else if (count_r >= CW'(MAX_RANGES)) begin
          out_nxt.status = ST_FULL; state_nxt = S_DONE;
        end else begin
          // shift tail up, from the top down to p
          src_nxt = count_r; state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (src_r == idx_r) begin
          ks_nxt = sv_r; ke_nxt = ev_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN_WR;
        end else begin
          mem_addr = AW'(src_r - CW'(1)); state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1; mem_addr = src_r[AW-1:0]; mem_wd = rd_q;
        src_nxt = src_r - CW'(1); state_nxt = S_SHIFT_RD;
      end
      S_MERGE_RD: begin
        // absorb following entries that touch entry k (idx_r)
        if (src_r < count_r) begin
          mem_addr = src_r[AW-1:0]; state_nxt = S_MERGE_W;
        end else begin
          count_nxt = idx_r + CW'(1); state_nxt = S_FIN_WR;
        end
      end
      S_MERGE_W: begin
        if (rd_s <= ke_r) begin
          if (rd_e > ke_r) ke_nxt = rd_e;
          src_nxt = src_r + CW'(1); state_nxt = S_MERGE_RD;
        end else begin
          // write merged entry, then compact the rest down
          mem_we = 1'b1; mem_addr = idx_r[AW-1:0]; mem_wd = {ks_r, ke_r};
          idx_nxt = idx_r + CW'(1); state_nxt = S_COMPACT_RD;
        end
      end
      S_COMPACT_RD: begin
        if (src_r < count_r) begin
          mem_addr = src_r[AW-1:0]; state_nxt = S_COMPACT_WR;
        end else begin
          count_nxt = idx_r; state_nxt = S_DONE;
        end
      end
      S_COMPACT_WR: begin
        mem_we = 1'b1; mem_addr = idx_r[AW-1:0]; mem_wd = rd_q;
        idx_nxt = idx_r + CW'(1); src_nxt = src_r + CW'(1);
        state_nxt = S_COMPACT_RD;
      end
      S_FIN_WR: begin
        mem_we = 1'b1; mem_addr = idx_r[AW-1:0]; mem_wd = {ks_r, ke_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_nxt.range_count = to_cnt(count_r);
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt; src_r <= src_nxt; cmd_r <= cmd_nxt;
    sv_r <= sv_nxt; ev_r <= ev_nxt; amt_r <= amt_nxt;
    ps_r <= ps_nxt; pe_r <= pe_nxt; hp_r <= hp_nxt;
    ks_r <= ks_nxt; ke_r <= ke_nxt; out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RANGES)) else $error("range count overflow");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN)) else $error("command not started");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result lost");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we) else $error("memory write while idle");
`endif
endmodule
`default_nettype wire

@@ sim/free_range_allocator_tb.sv @@
// testbench for the free range allocator: random command beats checked against a local table model
`default_nettype none
module free_range_allocator_tb;
  import fra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 256;
  localparam logic [31:0] NoRange = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  free_range_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // model of the free table
  logic [31:0] free_lo [TableDepth];
  logic [31:0] free_hi [TableDepth];
  int unsigned free_count = 0;

  in_item_t pending_cmds[$];
  out_item_t expected_results[$];
  int unsigned mismatches = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;

  function automatic int unsigned lower_bound(logic [31:0] v);
    int unsigned i;
    i = 0;
    while (i < free_count && free_lo[i] < v) i++;
    return i;
  endfunction

  function automatic void drop_entries(int unsigned from, int unsigned n);
    for (int unsigned i = from; i + n < free_count; i++) begin
      free_lo[i] = free_lo[i + n];
      free_hi[i] = free_hi[i + n];
    end
    free_count -= n;
  endfunction

  function automatic status_t model_put(logic [31:0] s, logic [31:0] e);
    int unsigned p;
    int unsigned k;
    int unsigned j;
    if (e == 0 || e < s) return ST_BAD;
    if (e == s) return ST_OK;
    p = lower_bound(s);
    if (p > 0 && free_hi[p - 1] >= s) begin
      k = p - 1;
      if (e > free_hi[k]) free_hi[k] = e;
    end else if (p < free_count && e >= free_lo[p]) begin
      k = p;
      free_lo[k] = s;
      if (e > free_hi[k]) free_hi[k] = e;
    end else begin
      if (free_count >= TableDepth) return ST_FULL;
      for (int unsigned i = free_count; i > p; i--) begin
        free_lo[i] = free_lo[i - 1];
        free_hi[i] = free_hi[i - 1];
      end
      free_lo[p] = s;
      free_hi[p] = e;
      free_count++;
      return ST_OK;
    end
    j = k + 1;
    while (j < free_count && free_lo[j] <= free_hi[k]) begin
      if (free_hi[j] > free_hi[k]) free_hi[k] = free_hi[j];
      j++;
    end
    drop_entries(k + 1, j - k - 1);
    return ST_OK;
  endfunction

  function automatic out_item_t predict_allocation(in_item_t c);
    out_item_t r;
    int unsigned p;
    r = '0;
    r.status = ST_OK;
    case (cmd_t'(c.cmd))
      CMD_PUT: begin
        r.status = model_put(c.start_value, c.end_value);
      end
      CMD_GET: begin
        if (free_count == 0 || c.amount == 0) begin
          r.status = ST_NONE;
          r.range_start = NoRange;
          r.range_end = NoRange;
        end else begin
          r.range_start = free_lo[0];
          if (free_hi[0] - free_lo[0] > c.amount) begin
            r.range_end = free_lo[0] + c.amount;
            free_lo[0] = r.range_end;
          end else begin
            r.range_end = free_hi[0];
            drop_entries(0, 1);
          end
        end
      end
      CMD_FIND: begin
        p = lower_bound(c.start_value);
        if (p < free_count && free_lo[p] == c.start_value) begin
          r.range_start = free_lo[p];
          r.range_end = free_hi[p];
        end else if (p > 0 && free_hi[p - 1] > c.start_value) begin
          r.range_start = free_lo[p - 1];
          r.range_end = free_hi[p - 1];
        end else begin
          r.status = ST_NONE;
          r.range_start = NoRange;
          r.range_end = NoRange;
        end
      end
      default: begin
        free_count = 0;
      end
    endcase
    r.range_count = free_count[CountBits-1:0];
    return r;
  endfunction

  function automatic in_item_t make_cmd(cmd_t op, logic [31:0] s, logic [31:0] e,
                                        logic [31:0] amt);
    in_item_t c;
    c.cmd = op;
    c.start_value = s;
    c.end_value = e;
    c.amount = amt;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4095);
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  // random commands: half are well-formed puts, with content in a range where merges happen
  function automatic in_item_t random_cmd();
    logic [31:0] s;
    logic [31:0] len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      s = ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 20000);
      len = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 300);
      if (s + len < s) len = ~s;
      return make_cmd(CMD_PUT, s, s + len, $urandom());
    end else if (pick < 55) begin
      return make_cmd(CMD_PUT, rand_word(), rand_word(), $urandom());
    end else if (pick < 75) begin
      len = ($urandom_range(0, 9) == 0) ? rand_word() : $urandom_range(0, 400);
      return make_cmd(CMD_GET, $urandom(), $urandom(), len);
    end else if (pick < 98) begin
      s = ($urandom_range(0, 5) == 0) ? rand_word() : $urandom_range(0, 21000);
      return make_cmd(CMD_FIND, s, $urandom(), $urandom());
    end
    return make_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom());
  endfunction

  // driver: bursts and gaps, valid held until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the beat
    end else begin
      if (in_valid) begin
        void'(pending_cmds.pop_front());
        expected_results.push_back(predict_allocation(in_data));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (hold_sender || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_cmds[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor with its own stall pattern
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.range_start !== want.range_start) begin
            $error("range_start expected %h actual %h", want.range_start,
                   out_data.range_start);
            mismatches++;
          end
          if (out_data.range_end !== want.range_end) begin
            $error("range_end expected %h actual %h", want.range_end, out_data.range_end);
            mismatches++;
          end
          if (out_data.range_count !== want.range_count) begin
            $error("range_count expected %0d actual %0d", want.range_count,
                   out_data.range_count);
            mismatches++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) out_ready <= 1'b1;
      else if (stall_phase < 60) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= (stall_phase % 7 < 3);
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, bad and empty puts, touching merges, extremes
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 5));
    pending_cmds.push_back(make_cmd(CMD_FIND, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 5, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 10, 9, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 7, 7, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 100, 200, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 200, 300, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 50, 100, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 400, 500, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 0, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 40, 450, 0));
    pending_cmds.push_back(make_cmd(CMD_FIND, 40, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FIND, 499, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FIND, 500, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FIND, 32'hFFFF_FFFE, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_GET, 0, 0, 10));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FIND, 45, 0, 0));
    wait_drained();

    // fill the table with non-touching ranges, then overflow it
    for (int unsigned i = 0; i <= TableDepth; i++)
      pending_cmds.push_back(make_cmd(CMD_PUT, i * 4, i * 4 + 2, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 2, 3, 0));
    pending_cmds.push_back(make_cmd(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(CMD_FIND, 1020, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0));

    for (int unsigned i = 0; i < 600; i++) begin
      pending_cmds.push_back(random_cmd());
      if (i == 300) begin
        wait_drained();
        hold_sender = 1'b1;
        repeat (50) @(posedge clk);
        hold_sender = 1'b0;
      end
      while (pending_cmds.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (1200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
